@@ hw/rtl/i2cseq_pkg.sv @@
package i2cseq_pkg;

  // Transfer buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int DEV_W  = 7;
  localparam int CIDX_W = 2;

  // Controller status codes
  localparam logic [BYTE_W-1:0] ST_BUS_ERR  = 8'h00;
  localparam logic [BYTE_W-1:0] ST_START    = 8'h08;
  localparam logic [BYTE_W-1:0] ST_RSTART   = 8'h10;
  localparam logic [BYTE_W-1:0] ST_SLAW_ACK = 8'h18;
  localparam logic [BYTE_W-1:0] ST_SLAW_NAK = 8'h20;
  localparam logic [BYTE_W-1:0] ST_TXD_ACK  = 8'h28;
  localparam logic [BYTE_W-1:0] ST_ARB_LOST = 8'h38;
  localparam logic [BYTE_W-1:0] ST_SLAR_ACK = 8'h40;
  localparam logic [BYTE_W-1:0] ST_RXD_ACK  = 8'h50;
  localparam logic [BYTE_W-1:0] ST_RXD_NAK  = 8'h58;

  // R/W bit appended to the slave address for a read
  localparam logic RW_READ = 1'b1;

  typedef enum logic [1:0] {
    FUNC_BUF_WR = 2'd0,
    FUNC_BUF_RD = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_EVENT  = 2'd3
  } func_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DEV_ADDR  = 2'd0,
    CFG_REG_ADDR  = 2'd1,
    CFG_XFER_LEN  = 2'd2,
    CFG_READ_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND
  } state_e;

  // One result item
  typedef struct packed {
    logic              data_write;
    logic [BYTE_W-1:0] data_byte;
    logic              ctl_write;
    logic              ctl_sta;
    logic              ctl_sto;
    logic              ctl_si;
    logic              ctl_aa;
    logic              clear_timeout;
    logic              done_res;
    logic              fault;
    logic [BYTE_W-1:0] read_byte;
    logic              last;
  } res_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic second;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic has_res;
    logic two_res;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/i2cseq_ctrl.sv @@
module i2cseq_ctrl import i2cseq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!sts_i.has_res || sts_i.out_free) begin
          state_d = sts_i.two_res ? S_SECOND : S_IDLE;
        end
      end
      S_SECOND: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    cmd_o.second  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = !sts_i.has_res || sts_i.out_free;
      end
      S_SECOND: begin
        cmd_o.second = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/i2cseq_dp.sv @@
module i2cseq_dp import i2cseq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  // input item
  input  logic [1:0]        func_i,
  input  logic [BYTE_W-1:0] buffer_index_i,
  input  logic [BYTE_W-1:0] buffer_byte_i,
  input  logic [BYTE_W-1:0] status_code_i,
  input  logic [BYTE_W-1:0] rx_data_i,
  input  logic              timeout_flag_i,
  // control
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  // result
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output res_t              res_o
);

  // Configuration registers
  logic [DEV_W-1:0]  dev_q;
  logic [BYTE_W-1:0] reg_q;
  logic [BYTE_W-1:0] len_q;
  logic              rmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= '0;
      reg_q   <= '0;
      len_q   <= '0;
      rmode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEV_ADDR:  dev_q   <= cfg_data_i[DEV_W-1:0];
        CFG_REG_ADDR:  reg_q   <= cfg_data_i;
        CFG_XFER_LEN:  len_q   <= cfg_data_i;
        CFG_READ_MODE: rmode_q <= cfg_data_i[0];
        default:       rmode_q <= rmode_q;
      endcase
    end
  end

  // Captured input item
  func_e             func_q;
  logic [BYTE_W-1:0] idx_q;
  logic [BYTE_W-1:0] bbyte_q;
  logic [BYTE_W-1:0] st_q;
  logic [BYTE_W-1:0] rx_q;
  logic              tmo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(func_i);
      idx_q   <= buffer_index_i;
      bbyte_q <= buffer_byte_i;
      st_q    <= status_code_i;
      rx_q    <= rx_data_i;
      tmo_q   <= timeout_flag_i;
    end
  end

  // Sequencer state
  logic [BYTE_W-1:0] bc_q, bc_d;
  mode_e             mode_q, mode_d;

  // Transfer buffer: read at capture, written at commit
  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_addr;
  logic              rd_ok;
  logic [BYTE_W-1:0] rd_q;
  logic              rd_ok_q;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  assign rd_addr = (func_e'(func_i) == FUNC_BUF_RD) ? buffer_index_i : bc_q;
  assign rd_ok   = (9'(rd_addr) < 9'(BUF_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q    <= mem[rd_addr[BUF_AW-1:0]];
      rd_ok_q <= rd_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && cmd_i.commit) begin
      mem[wr_addr[BUF_AW-1:0]] <= wr_data;
    end
  end

  // Item decode: result, state update, buffer write
  logic [BYTE_W-1:0] sla_w;
  logic [BYTE_W-1:0] bc_inc;
  logic [BYTE_W-1:0] rd_byte;
  logic              bc_ok;
  logic              idx_ok;
  logic              handled;
  res_t              res;
  logic              has_res;
  logic              two_res;

  assign sla_w   = {dev_q, 1'b0};
  assign bc_inc  = bc_q + 8'd1;
  assign rd_byte = rd_ok_q ? rd_q : '0;
  assign bc_ok   = (9'(bc_q) < 9'(BUF_DEPTH));
  assign idx_ok  = (9'(idx_q) < 9'(BUF_DEPTH));
  assign handled = (mode_q == MODE_TX) || (mode_q == MODE_RX);

  always_comb begin
    res     = '0;
    has_res = 1'b0;
    two_res = 1'b0;
    bc_d    = bc_q;
    mode_d  = mode_q;
    wr_en   = 1'b0;
    wr_addr = bc_q;
    wr_data = rx_q;
    case (func_q)
      FUNC_BUF_WR: begin
        wr_en   = idx_ok;
        wr_addr = idx_q;
        wr_data = bbyte_q;
      end
      FUNC_BUF_RD: begin
        has_res       = 1'b1;
        res.read_byte = rd_byte;
        res.last      = 1'b1;
      end
      FUNC_START: begin
        has_res       = 1'b1;
        bc_d          = '0;
        mode_d        = rmode_q ? MODE_RX : MODE_TX;
        res.ctl_write = 1'b1;
        res.ctl_sta   = 1'b1;
        res.last      = 1'b1;
      end
      FUNC_EVENT: begin
        if (tmo_q) begin
          has_res           = 1'b1;
          res.clear_timeout = 1'b1;
          res.last          = 1'b1;
        end else if (handled) begin
          has_res       = 1'b1;
          res.last      = 1'b1;
          res.ctl_write = 1'b1;
          res.ctl_si    = 1'b1;
          case (st_q)
            ST_START: begin
              res.data_write = 1'b1;
              res.data_byte  = sla_w;
            end
            ST_SLAW_ACK: begin
              res.data_write = 1'b1;
              res.data_byte  = reg_q;
            end
            ST_SLAW_NAK: begin
              res.ctl_sta = 1'b1;
              res.ctl_sto = 1'b1;
            end
            default: begin
              if (mode_q == MODE_TX) begin
                // register write sequence
                case (st_q)
                  ST_TXD_ACK: begin
                    if (bc_q < len_q) begin
                      res.data_write = 1'b1;
                      res.data_byte  = bc_ok ? rd_byte : '0;
                      bc_d           = bc_inc;
                    end else begin
                      res.ctl_sto  = 1'b1;
                      res.done_res = 1'b1;
                    end
                  end
                  ST_ARB_LOST: begin
                    res.ctl_sta = 1'b1;
                    res.ctl_aa  = 1'b1;
                  end
                  ST_BUS_ERR: begin
                    res.ctl_sto = 1'b1;
                    res.ctl_aa  = 1'b1;
                    res.last    = 1'b0;
                    two_res     = 1'b1;
                  end
                  default: begin
                    res.ctl_sto = 1'b1;
                    res.fault   = 1'b1;
                    mode_d      = MODE_NONE;
                  end
                endcase
              end else begin
                // register read sequence
                case (st_q)
                  ST_TXD_ACK: begin
                    if (len_q != '0) begin
                      res.ctl_sta = 1'b1;
                    end else begin
                      res.ctl_sto  = 1'b1;
                      res.done_res = 1'b1;
                    end
                  end
                  ST_RSTART: begin
                    res.data_write = 1'b1;
                    res.data_byte  = {dev_q, RW_READ};
                  end
                  ST_SLAR_ACK: begin
                    res.ctl_aa = (len_q > 8'd1);
                  end
                  ST_RXD_ACK: begin
                    wr_en      = bc_ok;
                    bc_d       = bc_inc;
                    res.ctl_aa = (len_q != '0) && (bc_inc < (len_q - 8'd1));
                  end
                  ST_RXD_NAK: begin
                    wr_en        = bc_ok;
                    bc_d         = bc_inc;
                    res.ctl_sto  = 1'b1;
                    res.done_res = 1'b1;
                  end
                  default: begin
                    res.ctl_sto = 1'b1;
                    res.fault   = 1'b1;
                    mode_d      = MODE_NONE;
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // Sequencer state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= '0;
      mode_q <= MODE_NONE;
    end else if (cmd_i.commit) begin
      bc_q   <= bc_d;
      mode_q <= mode_d;
    end
  end

  // Output register
  logic out_valid_q;
  res_t res_q;
  res_t res2;
  logic load;

  always_comb begin
    res2           = '0;
    res2.ctl_write = 1'b1;
    res2.ctl_si    = 1'b1;
    res2.ctl_aa    = 1'b1;
    res2.last      = 1'b1;
  end

  assign load = (cmd_i.commit && has_res) || cmd_i.second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.second) begin
      res_q <= res2;
    end else if (load) begin
      res_q <= res;
    end
  end

  assign sts_o.has_res  = has_res;
  assign sts_o.two_res  = two_res;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign res_o          = res_q;

endmodule

@@ hw/rtl/i2c_master_register_transfer_sequencer_top.sv @@
// Timing: an item is captured into the input and buffer read registers when accepted,
// and its result is registered in the output register once that register is free;
// a second result follows the first there. A stalled result holds the controller until
// the output register frees. The input stalls from acceptance until the item's results
// are committed, so a new item is taken only after the last one is through.
// Reset (rst_ni low, asynchronous): configuration, byte counter and handler mode
// clear to zero; the transfer buffer holds no reset value.
module i2c_master_register_transfer_sequencer_top import i2cseq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [BYTE_W-1:0] buffer_index_i,
  input  logic [BYTE_W-1:0] buffer_byte_i,
  input  logic [BYTE_W-1:0] status_code_i,
  input  logic [BYTE_W-1:0] rx_data_i,
  input  logic              timeout_flag_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              data_write_o,
  output logic [BYTE_W-1:0] data_byte_o,
  output logic              ctl_write_o,
  output logic              ctl_sta_o,
  output logic              ctl_sto_o,
  output logic              ctl_si_o,
  output logic              ctl_aa_o,
  output logic              clear_timeout_o,
  output logic              done_res_o,
  output logic              fault_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  // Transaction control
  i2cseq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Buffer, counters and result decode
  i2cseq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .buffer_index_i (buffer_index_i),
    .buffer_byte_i  (buffer_byte_i),
    .status_code_i  (status_code_i),
    .rx_data_i      (rx_data_i),
    .timeout_flag_i (timeout_flag_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .res_o          (res)
  );

  // Result fields
  assign data_write_o    = res.data_write;
  assign data_byte_o     = res.data_byte;
  assign ctl_write_o     = res.ctl_write;
  assign ctl_sta_o       = res.ctl_sta;
  assign ctl_sto_o       = res.ctl_sto;
  assign ctl_si_o        = res.ctl_si;
  assign ctl_aa_o        = res.ctl_aa;
  assign clear_timeout_o = res.clear_timeout;
  assign done_res_o      = res.done_res;
  assign fault_o         = res.fault;
  assign read_byte_o     = res.read_byte;
  assign last_o          = res.last;

endmodule
